@@ rtl/epr_pkg.sv @@
// ----------------------------------------------------------------------------
// epr_pkg
// Shared constants, types and the sine table generator for the Euler point
// rotation unit.
// ----------------------------------------------------------------------------
package epr_pkg;

  localparam int COORD_BITS_DEFAULT   = 32;
  localparam int SINE_ENTRIES_DEFAULT = 1024;

  // pi/2 in Q2.30
  localparam logic [63:0]        HALF_PI_Q30  = 64'd1686629713;
  localparam logic [15:0]        QUARTER_TURN = 16'h4000;
  localparam logic signed [15:0] Q15_MAX      = 16'sd32767;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    REG_ANGLE_X = 2'd0,
    REG_ANGLE_Y = 2'd1,
    REG_ANGLE_Z = 2'd2
  } reg_idx_t;

  // Coefficients of one plane rotation:
  //   a' = a*c + b*sa,  b' = a*sb + b*c
  typedef struct packed {
    logic               bypass;
    logic signed [15:0] c;
    logic signed [15:0] sa;
    logic signed [15:0] sb;
  } rot_coef_t;

  // Quarter-wave sine entry in Q1.15 from a Q2.30 angle, Taylor series
  // through x^17 with truncated terms. Evaluated at elaboration only.
  function automatic logic [14:0] sine_q15(input logic [63:0] xa);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] q;
    x2   = (xa * xa) >> 30;
    term = xa;
    sum  = $signed(xa);
    for (int k = 1; k <= 8; k++) begin
      term = (term * x2) >> 30;
      unique case (k)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        7:       term = term / 64'd210;
        default: term = term / 64'd272;
      endcase
      if (k[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    q = (sum + 64'sd16384) >>> 15;
    if (q > 64'sd32767) begin
      q = 64'sd32767;
    end
    return q[14:0];
  endfunction

endpackage

@@ rtl/epr_sincos.sv @@
// ----------------------------------------------------------------------------
// epr_sincos
// Looks up sine and cosine of the three angle registers in a quarter-wave
// table, one lookup per cycle, and holds the six results.
// ----------------------------------------------------------------------------
module epr_sincos import epr_pkg::*; #(
  parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2:0][15:0] angle,
  output logic [2:0][15:0] sin_val,
  output logic [2:0][15:0] cos_val,
  output logic             busy
);

  localparam int AW    = (SINE_TABLE_ENTRIES > 1) ? $clog2(SINE_TABLE_ENTRIES) : 1;
  localparam int PW    = AW + 14;
  localparam int SLOTS = 6;

  logic [14:0] rom [SINE_TABLE_ENTRIES];

  for (genvar g = 0; g < SINE_TABLE_ENTRIES; g++) begin : g_rom
    localparam logic [63:0] XA = (HALF_PI_Q30 * 64'(g)) / 64'(SINE_TABLE_ENTRIES);
    assign rom[g] = sine_q15(XA);
  end

  logic        pend;
  logic        run;
  logic [2:0]  cnt;
  logic        rd_valid;
  logic [1:0]  rd_axis;
  logic        rd_cos;
  logic        rd_neg;
  logic        rd_full;
  logic [14:0] rom_q;

  logic [1:0]         axis;
  logic               is_cos;
  logic [15:0]        ang;
  logic [14:0]        p;
  logic [14:0]        qp;
  logic [PW-1:0]      idx_prod;
  logic [AW-1:0]      idx;
  logic signed [15:0] mag;
  logic signed [15:0] val;

  // slot order: sin x, cos x, sin y, cos y, sin z, cos z
  assign axis     = cnt[2:1];
  assign is_cos   = cnt[0];
  assign ang      = angle[axis] + (is_cos ? QUARTER_TURN : 16'h0000);
  assign p        = {1'b0, ang[13:0]};
  assign qp       = ang[14] ? (15'(QUARTER_TURN) - p) : p;
  assign idx_prod = PW'(qp[13:0]) * PW'(SINE_TABLE_ENTRIES);
  assign idx      = idx_prod[PW-1:14];

  assign mag  = rd_full ? Q15_MAX : $signed({1'b0, rom_q});
  assign val  = rd_neg ? -mag : mag;
  assign busy = pend | run | rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 1'b1;
      run      <= 1'b0;
      cnt      <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= run;
      if (run) begin
        if (cnt == 3'(SLOTS - 1)) begin
          run <= 1'b0;
          cnt <= '0;
        end else begin
          cnt <= cnt + 3'd1;
        end
      end else if (pend) begin
        run  <= 1'b1;
        cnt  <= '0;
        pend <= 1'b0;
      end
      // a write during a sweep restarts it afterwards
      if (start) begin
        pend <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rom_q   <= rom[idx];
    rd_axis <= axis;
    rd_cos  <= is_cos;
    rd_neg  <= ang[15];
    rd_full <= qp[14];
    if (rd_valid) begin
      if (rd_cos) begin
        cos_val[rd_axis] <= val;
      end else begin
        sin_val[rd_axis] <= val;
      end
    end
  end

endmodule

@@ rtl/epr_rotate.sv @@
// ----------------------------------------------------------------------------
// epr_rotate
// Two-stage plane rotation of one point: products, then rounded and
// saturated sums. The third coordinate passes through, and with bypass set so does the whole point.
// ----------------------------------------------------------------------------
module epr_rotate import epr_pkg::*; #(
  parameter int    COORD_BITS = COORD_BITS_DEFAULT,
  parameter axis_t AXIS_A     = AXIS_Y,
  parameter axis_t AXIS_B     = AXIS_Z
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [2:0][COORD_BITS-1:0] in_pt,
  input  rot_coef_t                  coef,
  output logic                       out_valid,
  output logic [2:0][COORD_BITS-1:0] out_pt
);

  localparam int PW = COORD_BITS + 16;
  localparam logic signed [PW:0] RND = (PW+1)'(1 << 14);

  function automatic logic [COORD_BITS-1:0] rnd_sat(input logic signed [PW-1:0] u,
                                                    input logic signed [PW-1:0] w);
    logic signed [PW:0]   s;
    logic [COORD_BITS+1:0] sh;
    s  = (PW+1)'(u) + (PW+1)'(w) + RND;
    sh = s[PW:15];
    if (sh[COORD_BITS+1:COORD_BITS-1] == 3'b000 ||
        sh[COORD_BITS+1:COORD_BITS-1] == 3'b111) begin
      return sh[COORD_BITS-1:0];
    end
    return sh[COORD_BITS+1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                            : {1'b0, {(COORD_BITS-1){1'b1}}};
  endfunction

  logic signed [COORD_BITS-1:0] a;
  logic signed [COORD_BITS-1:0] b;
  logic signed [PW-1:0]         m_ac, m_bsa, m_asb, m_bc;

  assign a     = $signed(in_pt[AXIS_A]);
  assign b     = $signed(in_pt[AXIS_B]);
  assign m_ac  = a * $signed(coef.c);
  assign m_bsa = b * $signed(coef.sa);
  assign m_asb = a * $signed(coef.sb);
  assign m_bc  = b * $signed(coef.c);

  logic                       v1;
  logic [2:0][COORD_BITS-1:0] pt1;
  logic signed [PW-1:0]       p_ac, p_bsa, p_asb, p_bc;
  logic [2:0][COORD_BITS-1:0] pt_rot;

  always_comb begin
    pt_rot         = pt1;
    pt_rot[AXIS_A] = rnd_sat(p_ac, p_bsa);
    pt_rot[AXIS_B] = rnd_sat(p_asb, p_bc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt1    <= in_pt;
      p_ac   <= m_ac;
      p_bsa  <= m_bsa;
      p_asb  <= m_asb;
      p_bc   <= m_bc;
      out_pt <= coef.bypass ? pt1 : pt_rot;
    end
  end

endmodule

@@ rtl/euler_point_rotate_unit.sv @@
// ----------------------------------------------------------------------------
// euler_point_rotate_unit
// Rotates a Q16.16 point about x, then y, then z by three programmable
// binary angles (65536 = full turn), rounding and saturating each rotation.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_*       in         s_tvalid / s_tready    point_x, point_y, point_z
//  m_*       out        m_tvalid / m_tready    rotated_x, rotated_y, rotated_z
//  APB       in         psel/penable/pwrite    angle_x @0, angle_y @4, angle_z @8
//
//  One point per cycle while s_tready is high (two stages per axis).
//  After reset and after each angle write, sine/cosine are reloaded from the
//  quarter-wave table, one lookup per cycle, and s_tready is low until done.
//  When m_tvalid is high and m_tready low the whole pipeline holds.
// ----------------------------------------------------------------------------
module euler_point_rotate_unit import epr_pkg::*; #(
  parameter int COORD_BITS         = COORD_BITS_DEFAULT,
  parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // point_x, point_y, point_z, zero pad
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]      s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // rotated_x, rotated_y, rotated_z, zero pad
  output logic [((3*COORD_BITS+7)/8)*8-1:0]      m_tdata,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [3:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  localparam int DW = ((3*COORD_BITS+7)/8)*8;

  logic [15:0] angle_x, angle_y, angle_z;
  logic        cfg_wr;
  reg_idx_t    reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_x <= '0;
      angle_y <= '0;
      angle_z <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ANGLE_X: angle_x <= pwdata[15:0];
        REG_ANGLE_Y: angle_y <= pwdata[15:0];
        REG_ANGLE_Z: angle_z <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ANGLE_X: prdata = {16'h0000, angle_x};
      REG_ANGLE_Y: prdata = {16'h0000, angle_y};
      REG_ANGLE_Z: prdata = {16'h0000, angle_z};
      default:     prdata = '0;
    endcase
  end

  logic [2:0][15:0] angles, sin_val, cos_val;
  logic             busy;

  assign angles = {angle_z, angle_y, angle_x};

  epr_sincos #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_sincos (
    .clk    (clk),
    .rst    (rst),
    .start  (cfg_wr),
    .angle  (angles),
    .sin_val(sin_val),
    .cos_val(cos_val),
    .busy   (busy)
  );

  rot_coef_t coef_x, coef_y, coef_z;

  always_comb begin
    coef_x.bypass = (angle_x == 16'h0000);
    coef_x.c      = $signed(cos_val[AXIS_X]);
    coef_x.sa     = $signed(sin_val[AXIS_X]);
    coef_x.sb     = -$signed(sin_val[AXIS_X]);
    coef_y.bypass = (angle_y == 16'h0000);
    coef_y.c      = $signed(cos_val[AXIS_Y]);
    coef_y.sa     = -$signed(sin_val[AXIS_Y]);
    coef_y.sb     = $signed(sin_val[AXIS_Y]);
    coef_z.bypass = (angle_z == 16'h0000);
    coef_z.c      = $signed(cos_val[AXIS_Z]);
    coef_z.sa     = $signed(sin_val[AXIS_Z]);
    coef_z.sb     = -$signed(sin_val[AXIS_Z]);
  end

  logic                       en;
  logic                       in_valid;
  logic [2:0][COORD_BITS-1:0] pt_in, pt_x, pt_y, pt_z;
  logic                       v_x, v_y;

  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en & ~busy & ~cfg_wr;
  assign in_valid = s_tvalid & s_tready;
  assign pt_in    = s_tdata[3*COORD_BITS-1:0];
  assign m_tdata  = DW'(pt_z);

  epr_rotate #(
    .COORD_BITS(COORD_BITS), .AXIS_A(AXIS_Y), .AXIS_B(AXIS_Z)
  ) u_rot_x (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_valid), .in_pt(pt_in), .coef(coef_x),
    .out_valid(v_x), .out_pt(pt_x)
  );

  epr_rotate #(
    .COORD_BITS(COORD_BITS), .AXIS_A(AXIS_X), .AXIS_B(AXIS_Z)
  ) u_rot_y (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v_x), .in_pt(pt_x), .coef(coef_y),
    .out_valid(v_y), .out_pt(pt_y)
  );

  epr_rotate #(
    .COORD_BITS(COORD_BITS), .AXIS_A(AXIS_X), .AXIS_B(AXIS_Y)
  ) u_rot_z (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v_y), .in_pt(pt_y), .coef(coef_z),
    .out_valid(m_tvalid), .out_pt(pt_z)
  );

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for euler_point_rotate_unit. Points stream in on the
// s_ side and are predicted here with a chained x/y/z rotation built on an
// independent quarter-wave sine table. Every rotated point on the m_ side is
// compared per coordinate. Angles are programmed and read back over APB
// between bursts. Sender gaps and receiver stalls vary by phase, and one long
// receiver hold-off backs the pipeline up.
// ----------------------------------------------------------------------------
module tb;
  import epr_pkg::*;

  localparam int SINE_N       = SINE_ENTRIES_DEFAULT;
  localparam int PIPE_LATENCY = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_PHASES      = 4;
  localparam int SETTINGS_PER_PHASE = 4;
  localparam int POINTS_PER_SETTING = 85;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

  // register index with no register behind it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // x in the low bits, matching the tdata layout
  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } point_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // point_x, point_y, point_z
  logic [95:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // rotated_x, rotated_y, rotated_z
  logic [95:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  euler_point_rotate_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  int          sine_lut [SINE_N];
  logic [15:0] angle_shadow [3];
  point_t      pending_rotations [$];

  int     send_idle_pct = 0;
  int     stall_pct     = 0;
  int     hold_left     = 0;
  int     fail_count    = 0;
  int     points_sent   = 0;
  int     points_checked = 0;
  int     setting_count = 0;
  int     cycle_count   = 0;
  point_t got_pt;
  point_t want_pt;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rotations outstanding", cycle_count,
               pending_rotations.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------- predictor ----------------

  function automatic int taylor_sine(int unsigned idx);
    longint unsigned xa;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    xa   = (HALF_PI_Q30 * idx) / SINE_N;
    x2   = (xa * xa) >> 30;
    term = xa;
    acc  = $signed(xa);
    for (int k = 1; k <= 8; k++) begin
      term = (term * x2) >> 30;
      term = term / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 64'sd16384) >>> 15;
    if (acc > 32767) begin
      acc = 32767;
    end
    return int'(acc);
  endfunction

  function automatic int quarter_sine(int unsigned p);
    int unsigned idx;
    if (p >= 16384) begin
      return 32767;
    end
    idx = (p * SINE_N) >> 14;
    if (idx >= SINE_N) begin
      idx = SINE_N - 1;
    end
    return sine_lut[idx];
  endfunction

  function automatic int sine_at(logic [15:0] a);
    int unsigned p;
    p = a[13:0];
    case (a[15:14])
      2'd0:    return quarter_sine(p);
      2'd1:    return quarter_sine(16384 - p);
      2'd2:    return -quarter_sine(p);
      default: return -quarter_sine(16384 - p);
    endcase
  endfunction

  function automatic int cosine_at(logic [15:0] a);
    logic [15:0] shifted;
    shifted = a + QUARTER_TURN;
    return sine_at(shifted);
  endfunction

  // a*c + b*d, round half up at Q1.15, saturate to 32 bits
  function automatic longint rot_mac(longint a, longint c, longint b, longint d);
    longint acc;
    acc = (a * c + b * d + 64'sd16384) >>> 15;
    if (acc > SAT_HI) begin
      acc = SAT_HI;
    end
    if (acc < SAT_LO) begin
      acc = SAT_LO;
    end
    return acc;
  endfunction

  function automatic point_t rotate_xyz(point_t p);
    longint x;
    longint y;
    longint z;
    longint nx;
    longint ny;
    longint nz;
    int     s;
    int     c;
    point_t r;
    x = p.x;
    y = p.y;
    z = p.z;
    if (angle_shadow[REG_ANGLE_X] != 16'd0) begin
      s  = sine_at(angle_shadow[REG_ANGLE_X]);
      c  = cosine_at(angle_shadow[REG_ANGLE_X]);
      ny = rot_mac(y, c, z, s);
      nz = rot_mac(y, -s, z, c);
      y  = ny;
      z  = nz;
    end
    if (angle_shadow[REG_ANGLE_Y] != 16'd0) begin
      s  = sine_at(angle_shadow[REG_ANGLE_Y]);
      c  = cosine_at(angle_shadow[REG_ANGLE_Y]);
      nx = rot_mac(x, c, z, -s);
      nz = rot_mac(x, s, z, c);
      x  = nx;
      z  = nz;
    end
    if (angle_shadow[REG_ANGLE_Z] != 16'd0) begin
      s  = sine_at(angle_shadow[REG_ANGLE_Z]);
      c  = cosine_at(angle_shadow[REG_ANGLE_Z]);
      nx = rot_mac(x, c, y, s);
      ny = rot_mac(x, -s, y, c);
      x  = nx;
      y  = ny;
    end
    r.x = x[31:0];
    r.y = y[31:0];
    r.z = z[31:0];
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic logic signed [31:0] corner_coord(int i);
    case (i % 6)
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4:       return 32'sd1;
      default: return 32'sh0001_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0, 1:    return $urandom();
      2:       return $urandom_range(33554431) - 32'sd16777216;
      3:       return $urandom_range(131071) - 32'sd65536;
      4:       return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
      default: return corner_coord($urandom_range(5));
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.x = rand_coord();
    p.y = rand_coord();
    p.z = rand_coord();
    return p;
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(7))
      0:       return 16'd0;
      1: begin
        case ($urandom_range(4))
          0:       return 16'd1;
          1:       return 16'h4000;
          2:       return 16'h8000;
          3:       return 16'hc000;
          default: return 16'hffff;
        endcase
      end
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic point_t corner_point(int i);
    point_t p;
    p.x = corner_coord(i);
    p.y = corner_coord(i + 1);
    p.z = corner_coord(i + 3);
    return p;
  endfunction

  // ---------------- bus tasks ----------------

  // valid stays up after the transfer; drain_points or an idle gap in the next call lowers it
  task automatic send_point(point_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    do begin
      @(posedge clk);
    end while (!s_tready);
    pending_rotations.push_back(rotate_xyz(p));
    points_sent++;
  endtask

  task automatic drain_points();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_rotations.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    if (idx <= REG_ANGLE_Z) begin
      angle_shadow[idx] = value[15:0];
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read_check(reg_idx_t idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    if (prdata[15:0] !== angle_shadow[idx]) begin
      $error("readback %s: expected %h, got %h", idx.name(), angle_shadow[idx],
             prdata[15:0]);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_angles(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
    drain_points();
    apb_write(REG_ANGLE_X, {16'h0000, ax});
    apb_write(REG_ANGLE_Y, {16'h0000, ay});
    apb_write(REG_ANGLE_Z, {16'h0000, az});
    apb_read_check(REG_ANGLE_X);
    apb_read_check(REG_ANGLE_Y);
    apb_read_check(REG_ANGLE_Z);
    setting_count++;
  endtask

  // ---------------- receiver and checker ----------------

  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_pt = m_tdata;
      if (pending_rotations.size() == 0) begin
        $error("rotated point %h with no input outstanding", m_tdata);
        fail_count++;
      end else begin
        want_pt = pending_rotations.pop_front();
        points_checked++;
        if (got_pt.x !== want_pt.x) begin
          $error("rotated_x: expected %0d, got %0d", want_pt.x, got_pt.x);
          fail_count++;
        end
        if (got_pt.y !== want_pt.y) begin
          $error("rotated_y: expected %0d, got %0d", want_pt.y, got_pt.y);
          fail_count++;
        end
        if (got_pt.z !== want_pt.z) begin
          $error("rotated_z: expected %0d, got %0d", want_pt.z, got_pt.z);
          fail_count++;
        end
      end
    end
  end

  // ---------------- tests ----------------

  // angles are zero out of reset, so points pass straight through
  task automatic test_reset_state();
    apb_read_check(REG_ANGLE_X);
    apb_read_check(REG_ANGLE_Y);
    apb_read_check(REG_ANGLE_Z);
    for (int i = 0; i < 5; i++) begin
      send_point(corner_point(i));
    end
    drain_points();
  endtask

  // quadrant edges, one axis at a time, then mixed extremes and 45 degree
  // turns of full-scale points that have to saturate
  task automatic test_cardinal_angles();
    logic [15:0] ax [5] = '{16'h4000, 16'h0000, 16'h0000, 16'hffff, 16'h2000};
    logic [15:0] ay [5] = '{16'h0000, 16'h8000, 16'h0000, 16'h0001, 16'h2000};
    logic [15:0] az [5] = '{16'h0000, 16'h0000, 16'hc000, 16'h2000, 16'h2000};
    point_t      p;
    for (int s = 0; s < 5; s++) begin
      set_angles(ax[s], ay[s], az[s]);
      for (int i = 0; i < 2 + s / 3; i++) begin
        p = corner_point(s + i);
        if (s == 4) begin
          p.x = (i == 1) ? COORD_MIN : COORD_MAX;
          p.y = p.x;
          p.z = p.x;
        end
        send_point(p);
      end
    end
    drain_points();
  endtask

  // upper data bits are dropped and the unused address is ignored
  task automatic test_register_writes();
    drain_points();
    apb_write(REG_ANGLE_X, 32'habcd_4000);
    apb_write(REG_UNUSED,  32'h0000_1234);
    apb_write(REG_ANGLE_Y, 32'hffff_ffff);
    apb_write(REG_ANGLE_Z, 32'h0001_0000);
    apb_read_check(REG_ANGLE_X);
    apb_read_check(REG_ANGLE_Y);
    apb_read_check(REG_ANGLE_Z);
    setting_count++;
    for (int i = 0; i < 3; i++) begin
      send_point(corner_point(i + 2));
    end
    drain_points();
  endtask

  task automatic test_random_streams();
    int idle_mix  [RANDOM_PHASES] = '{0, 72, 0, 34};
    int stall_mix [RANDOM_PHASES] = '{0, 0, 72, 34};
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      send_idle_pct = idle_mix[ph];
      stall_pct     = stall_mix[ph];
      for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
        set_angles(rand_angle(), rand_angle(), rand_angle());
        repeat (POINTS_PER_SETTING) send_point(rand_point());
      end
    end
    drain_points();
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // receiver stops for a long stretch while points keep coming
  task automatic test_output_hold();
    set_angles(rand_angle(), rand_angle(), 16'h1234);
    hold_left = HOLD_CYCLES;
    repeat (60) send_point(rand_point());
    drain_points();
  endtask

  initial begin
    for (int i = 0; i < SINE_N; i++) begin
      sine_lut[i] = taylor_sine(i);
    end
    for (int i = 0; i < 3; i++) begin
      angle_shadow[i] = 16'd0;
    end
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_cardinal_angles();
    test_register_writes();
    test_random_streams();
    test_output_hold();

    repeat (4 * PIPE_LATENCY) @(posedge clk);
    $display("%0d points sent, %0d rotations checked, %0d angle settings",
             points_sent, points_checked, setting_count);
    $display("traffic: back-to-back, sparse sender, stalling receiver, both, and a %0d-cycle hold",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
